[src/mbfc_pkg.sv]
package mbfc_pkg;

    // Sizes
    localparam int LENGTH_BITS_DEF = 9;
    localparam int LEN_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_HIGH_FIRST = 2'd2;

    // Reset value of the own address configuration register
    localparam logic [7:0] OWN_ADDRESS_RST = 8'd1;

    // Roles
    localparam logic ROLE_SLAVE  = 1'b0;
    localparam logic ROLE_MASTER = 1'b1;

    // Station addresses
    localparam logic [7:0] ADDR_BROADCAST = 8'd0;
    localparam logic [7:0] ADDR_MAX       = 8'd247;

    // CRC-16/MODBUS, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame positions of the captured header bytes
    localparam int POS_STATION = 0;
    localparam int POS_FC      = 1;
    localparam int POS_H2      = 2;
    localparam int POS_H3      = 6;
    localparam int POS_H4      = 10;

    // Smallest frame that gets a full check
    localparam int MIN_FRAME = 4;

    // Function codes
    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS    = 8'h10;
    localparam logic [7:0] FC_READ_FILE     = 8'h14;
    localparam logic [7:0] FC_WRITE_FILE    = 8'h15;
    localparam logic [7:0] FC_MASK_WRITE    = 8'h16;
    localparam logic [7:0] FC_RW_REGS       = 8'h17;
    localparam logic [7:0] FC_ENC_IFACE     = 8'h2B;
    localparam logic [7:0] FC_EXC_FLAG      = 8'h80;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_SHORT      = 3'd0,
        ST_ADDR_REJ   = 3'd1,
        ST_ACCEPTED   = 3'd2,
        ST_CRC_BAD    = 3'd3,
        ST_TRUNCATED  = 3'd4,
        ST_UNKNOWN_FC = 3'd5
    } t_status;

    // Configuration set
    typedef struct packed {
        logic       role;
        logic [7:0] own_address;
        logic       crc_high_first;
    } t_cfg;

    // Advance the CRC over one byte, one bit per step
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Expected frame length for a function code; zero for an unknown code
    function automatic logic [LEN_W-1:0] table_length(logic role, logic [7:0] fc,
                                                      logic [7:0] h2, logic [7:0] h3,
                                                      logic [7:0] h4);
        logic [LEN_W-1:0] len;
        len = '0;
        if (role == ROLE_SLAVE) begin
            case (fc)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
                FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG: len = 9'd8;
                FC_WRITE_COILS, FC_WRITE_REGS:              len = {1'b0, h3} + 9'd9;
                FC_READ_FILE, FC_WRITE_FILE:                len = {1'b0, h2} + 9'd5;
                FC_MASK_WRITE:                              len = 9'd10;
                FC_RW_REGS:                                 len = {1'b0, h4} + 9'd13;
                FC_ENC_IFACE:                               len = 9'd7;
                default:                                    len = '0;
            endcase
        end else begin
            case (fc)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                FC_READ_FILE, FC_WRITE_FILE, FC_RW_REGS:    len = {1'b0, h2} + 9'd5;
                FC_WRITE_COIL, FC_WRITE_REG,
                FC_WRITE_COILS, FC_WRITE_REGS:              len = 9'd8;
                FC_MASK_WRITE:                              len = 9'd10;
                FC_READ_COILS | FC_EXC_FLAG, FC_READ_DISCRETE | FC_EXC_FLAG,
                FC_READ_HOLDING | FC_EXC_FLAG, FC_READ_INPUT | FC_EXC_FLAG,
                FC_WRITE_COIL | FC_EXC_FLAG, FC_WRITE_REG | FC_EXC_FLAG,
                FC_WRITE_COILS | FC_EXC_FLAG, FC_WRITE_REGS | FC_EXC_FLAG,
                FC_READ_FILE | FC_EXC_FLAG, FC_WRITE_FILE | FC_EXC_FLAG,
                FC_MASK_WRITE | FC_EXC_FLAG, FC_RW_REGS | FC_EXC_FLAG:
                                                            len = 9'd5;
                FC_ENC_IFACE:                               len = 9'd13;
                FC_ENC_IFACE | FC_EXC_FLAG:                 len = 9'd6;
                default:                                    len = '0;
            endcase
        end
        return len;
    endfunction

endpackage

[src/mbfc_in_if.sv]
interface mbfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

[src/mbfc_out_if.sv]
interface mbfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] station;
    logic [7:0] function_code;
    logic [8:0] message_length;
    logic [8:0] received_length;

    modport source (output valid, output status, output station, output function_code,
                    output message_length, output received_length, input ready);
    modport sink   (input valid, input status, input station, input function_code,
                    input message_length, input received_length, output ready);
endinterface

[src/modbus_rtu_frame_checker.sv]
// Channel    Dir  Payload                                                   Handshake
// i_in       in   data_byte[7:0], frame_end                                 valid/ready
// o_out      out  status[2:0], station[7:0], function_code[7:0],            valid/ready
//                 message_length[8:0], received_length[8:0]
// i_cfg_*    in   i_cfg_idx[1:0], i_cfg_data[7:0]                           i_cfg_we
//
// One byte per cycle while no frame_end byte waits: a byte sits in the input register,
// where the CRC step, header capture and length table run, and the verdict lands in the
// result register. Bytes without frame_end give no item.
// Synchronous active-low reset clears the byte count and valids, sets the running CRC to
// its initial value and loads the configuration reset values. A frame_end byte waits in
// the input register while the result register is full and not taken; other bytes pass regardless of the output side.
module modbus_rtu_frame_checker #(
    parameter int LENGTH_BITS = mbfc_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbfc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mbfc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mbfc_in_if.sink                            i_in,
    mbfc_out_if.source                         o_out
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    mbfc_pkg::t_cfg r_cfg;

    // Input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_end;

    // Frame state
    logic [LENGTH_BITS-1:0] r_count;
    logic [15:0]            r_crc_run;
    logic [15:0]            r_crc_latched;
    logic [15:0]            r_crc_received;
    logic [7:0]             r_hdr_station;
    logic [7:0]             r_hdr_fc;
    logic [7:0]             r_hdr_h2;
    logic [7:0]             r_hdr_h3;
    logic [7:0]             r_hdr_h4;

    // Result register
    logic                           r_out_valid;
    mbfc_pkg::t_status              r_out_status;
    logic [7:0]                     r_out_station;
    logic [7:0]                     r_out_fc;
    logic [mbfc_pkg::LEN_W-1:0]     r_out_msg_len;
    logic [mbfc_pkg::LEN_W-1:0]     r_out_rx_len;

    logic out_free;
    logic s1_go;

    logic [LENGTH_BITS-1:0]         n_count;
    logic [7:0]                     n_hdr_station;
    logic [7:0]                     n_hdr_fc;
    logic [7:0]                     n_hdr_h2;
    logic [7:0]                     n_hdr_h3;
    logic [7:0]                     n_hdr_h4;
    logic [mbfc_pkg::LEN_W-1:0]     exp_len;
    logic [mbfc_pkg::LEN_W-1:0]     exp_m1;
    logic [mbfc_pkg::LEN_W-1:0]     exp_m2;
    logic [15:0]                    n_crc_latched;
    logic [15:0]                    n_crc_received;

    mbfc_pkg::t_status              v_status;
    logic [7:0]                     v_station;
    logic [7:0]                     v_fc;
    logic [mbfc_pkg::LEN_W-1:0]     v_msg_len;

    // Handshake: hold a frame_end byte until the result register frees up
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && (!r_s1_end || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role           <= 1'b0;
            r_cfg.own_address    <= mbfc_pkg::OWN_ADDRESS_RST;
            r_cfg.crc_high_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbfc_pkg::CFG_ROLE:           r_cfg.role           <= i_cfg_data[0];
                mbfc_pkg::CFG_OWN_ADDRESS:    r_cfg.own_address    <= i_cfg_data;
                mbfc_pkg::CFG_CRC_HIGH_FIRST: r_cfg.crc_high_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture header bytes at their positions
    always_comb begin
        n_hdr_station = (r_count == LENGTH_BITS'(mbfc_pkg::POS_STATION)) ? r_s1_byte
                                                                          : r_hdr_station;
        n_hdr_fc      = (r_count == LENGTH_BITS'(mbfc_pkg::POS_FC)) ? r_s1_byte : r_hdr_fc;
        n_hdr_h2      = (r_count == LENGTH_BITS'(mbfc_pkg::POS_H2)) ? r_s1_byte : r_hdr_h2;
        n_hdr_h3      = (r_count == LENGTH_BITS'(mbfc_pkg::POS_H3)) ? r_s1_byte : r_hdr_h3;
        n_hdr_h4      = (r_count == LENGTH_BITS'(mbfc_pkg::POS_H4)) ? r_s1_byte : r_hdr_h4;
    end

    assign exp_len = mbfc_pkg::table_length(r_cfg.role, n_hdr_fc, n_hdr_h2, n_hdr_h3,
                                            n_hdr_h4);
    assign exp_m1  = exp_len - 9'd1;
    assign exp_m2  = exp_len - 9'd2;

    // Latch the CRC and grab the received CRC bytes at the frame tail
    always_comb begin
        n_crc_latched  = r_crc_latched;
        n_crc_received = r_crc_received;
        if (exp_len != '0) begin
            if (r_count == LENGTH_BITS'(exp_m2)) begin
                n_crc_latched  = r_crc_run;
                n_crc_received = {r_s1_byte, r_crc_received[7:0]};
            end else if (r_count == LENGTH_BITS'(exp_m1)) begin
                n_crc_received = {r_crc_received[15:8], r_s1_byte};
            end
        end
    end

    // Saturating byte count
    assign n_count = (r_count != COUNT_MAX) ? r_count + 1'b1 : COUNT_MAX;

    mbfc_verdict #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_verdict (
        .i_cfg          (r_cfg),
        .i_station      (n_hdr_station),
        .i_fc           (n_hdr_fc),
        .i_count        (n_count),
        .i_exp_len      (exp_len),
        .i_crc_latched  (n_crc_latched),
        .i_crc_received (n_crc_received),
        .o_status       (v_status),
        .o_station      (v_station),
        .o_fc           (v_fc),
        .o_msg_len      (v_msg_len)
    );

    // Control state: input valid, count, running, latched and received CRC, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_count        <= '0;
            r_crc_run      <= mbfc_pkg::CRC_INIT;
            r_crc_latched  <= '0;
            r_crc_received <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_go) begin
                r_crc_latched  <= n_crc_latched;
                r_crc_received <= n_crc_received;
                if (r_s1_end) begin
                    r_count   <= '0;
                    r_crc_run <= mbfc_pkg::CRC_INIT;
                end else begin
                    r_count   <= n_count;
                    r_crc_run <= mbfc_pkg::crc16_byte(r_crc_run, r_s1_byte);
                end
            end
            if (s1_go && r_s1_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: input byte, header bytes, result fields
    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_end  <= i_in.frame_end;
        end
        if (s1_go) begin
            r_hdr_station <= n_hdr_station;
            r_hdr_fc      <= n_hdr_fc;
            r_hdr_h2      <= n_hdr_h2;
            r_hdr_h3      <= n_hdr_h3;
            r_hdr_h4      <= n_hdr_h4;
        end
        if (s1_go && r_s1_end) begin
            r_out_status  <= v_status;
            r_out_station <= v_station;
            r_out_fc      <= v_fc;
            r_out_msg_len <= v_msg_len;
            r_out_rx_len  <= n_count[mbfc_pkg::LEN_W-1:0];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.station         = r_out_station;
    assign o_out.function_code   = r_out_fc;
    assign o_out.message_length  = r_out_msg_len;
    assign o_out.received_length = r_out_rx_len;

endmodule

[src/mbfc_verdict.sv]
module mbfc_verdict #(
    parameter int LENGTH_BITS = mbfc_pkg::LENGTH_BITS_DEF
) (
    input  mbfc_pkg::t_cfg                i_cfg,
    input  logic [7:0]                    i_station,
    input  logic [7:0]                    i_fc,
    input  logic [LENGTH_BITS-1:0]        i_count,
    input  logic [mbfc_pkg::LEN_W-1:0]    i_exp_len,
    input  logic [15:0]                   i_crc_latched,
    input  logic [15:0]                   i_crc_received,
    output mbfc_pkg::t_status             o_status,
    output logic [7:0]                    o_station,
    output logic [7:0]                    o_fc,
    output logic [mbfc_pkg::LEN_W-1:0]    o_msg_len
);

    logic        addr_ok;
    logic [15:0] crc_calc;

    // Check the station address for the role
    always_comb begin
        if (i_cfg.role == mbfc_pkg::ROLE_SLAVE) begin
            addr_ok = (i_station == i_cfg.own_address) ||
                      (i_station == mbfc_pkg::ADDR_BROADCAST);
        end else begin
            addr_ok = (i_station != mbfc_pkg::ADDR_BROADCAST) &&
                      (i_station <= mbfc_pkg::ADDR_MAX);
        end
    end

    // Order the computed CRC as it appears on the wire
    assign crc_calc = i_cfg.crc_high_first ? i_crc_latched
                                           : {i_crc_latched[7:0], i_crc_latched[15:8]};

    // Pick the verdict
    always_comb begin
        o_status  = mbfc_pkg::ST_SHORT;
        o_station = i_station;
        o_fc      = i_fc;
        o_msg_len = '0;
        if (i_count < LENGTH_BITS'(mbfc_pkg::MIN_FRAME)) begin
            o_status  = mbfc_pkg::ST_SHORT;
            o_station = '0;
            o_fc      = '0;
        end else if (!addr_ok) begin
            o_status = mbfc_pkg::ST_ADDR_REJ;
        end else if (i_exp_len == '0) begin
            o_status  = mbfc_pkg::ST_UNKNOWN_FC;
            o_msg_len = i_count[mbfc_pkg::LEN_W-1:0];
        end else begin
            o_msg_len = i_exp_len;
            if (i_count < LENGTH_BITS'(i_exp_len)) begin
                o_status = mbfc_pkg::ST_TRUNCATED;
            end else if (crc_calc == i_crc_received) begin
                o_status = mbfc_pkg::ST_ACCEPTED;
            end else begin
                o_status = mbfc_pkg::ST_CRC_BAD;
            end
        end
    end

endmodule

[tb/tb.sv]
module tb;

    localparam logic [mbfc_pkg::LEN_W-1:0] COUNT_TOP     = '1;
    localparam int                         SETTLE_CYCLES = 6;
    localparam int                         HOLD_CYCLES   = 200;
    localparam int                         HOLD_AFTER    = 4;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_wire_byte;

    typedef struct packed {
        mbfc_pkg::t_status          status;
        logic [7:0]                 station;
        logic [7:0]                 fc;
        logic [mbfc_pkg::LEN_W-1:0] msg_len;
        logic [mbfc_pkg::LEN_W-1:0] rx_len;
    } t_verdict;

    typedef enum {
        FR_GOOD, FR_TAIL, FR_FLIP, FR_CUT, FR_SWAP, FR_NOISE, FR_RUNT, FR_LONG
    } t_frame_kind;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mbfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mbfc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    mbfc_in_if  byte_ch ();
    mbfc_out_if verdict_ch ();

    modbus_rtu_frame_checker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (byte_ch),
        .o_out      (verdict_ch)
    );

    // Byte stream waiting for the driver, the frame being built, verdicts due
    t_wire_byte tx_bytes[$];
    t_wire_byte drv_item;
    logic [7:0] frame_buf[$];
    t_verdict   verdicts_due[$];

    // Predictor configuration
    logic       cfg_role     = mbfc_pkg::ROLE_SLAVE;
    logic [7:0] cfg_addr     = mbfc_pkg::OWN_ADDRESS_RST;
    logic       cfg_hi_first = 1'b0;

    // Predictor state
    logic [mbfc_pkg::LEN_W-1:0] m_count   = '0;
    logic [15:0]                m_crc     = mbfc_pkg::CRC_INIT;
    logic [15:0]                m_crc_at  = '0;
    logic [15:0]                m_rx_crc  = '0;
    logic [7:0]                 m_hdr [5] = '{default: 8'h00};
    logic [mbfc_pkg::LEN_W-1:0] m_exp_len = '0;

    // Flow control and bookkeeping
    int   gap_left      = 0;
    int   stall_left    = 0;
    logic hold_out      = 1'b0;
    logic quiet         = 1'b0;
    int   hold_count;
    int   bytes_taken   = 0;
    int   frames_queued = 0;
    int   verdicts_seen = 0;
    int   fail_count    = 0;
    int   verdict_tally [6] = '{default: 0};

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // CRC-16/MODBUS over one byte, reflected
    function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = (c >> 1) ^ (c[0] ? mbfc_pkg::CRC_POLY : 16'h0000);
        return c;
    endfunction

    // Expected frame length by role and function code; zero when the code is unknown
    function automatic logic [mbfc_pkg::LEN_W-1:0] frame_len(logic role, logic [7:0] fc,
                                                            logic [7:0] h2, logic [7:0] h3,
                                                            logic [7:0] h4);
        logic [7:0] base;
        base = fc & ~mbfc_pkg::FC_EXC_FLAG;
        if (role == mbfc_pkg::ROLE_SLAVE) begin
            case (fc)
                mbfc_pkg::FC_READ_COILS, mbfc_pkg::FC_READ_DISCRETE,
                mbfc_pkg::FC_READ_HOLDING, mbfc_pkg::FC_READ_INPUT,
                mbfc_pkg::FC_WRITE_COIL, mbfc_pkg::FC_WRITE_REG:  return 9'd8;
                mbfc_pkg::FC_WRITE_COILS, mbfc_pkg::FC_WRITE_REGS: return {1'b0, h3} + 9'd9;
                mbfc_pkg::FC_READ_FILE, mbfc_pkg::FC_WRITE_FILE:   return {1'b0, h2} + 9'd5;
                mbfc_pkg::FC_MASK_WRITE:                           return 9'd10;
                mbfc_pkg::FC_RW_REGS:                              return {1'b0, h4} + 9'd13;
                mbfc_pkg::FC_ENC_IFACE:                            return 9'd7;
                default:                                           return '0;
            endcase
        end
        // Exception replies in master role
        if (fc[7]) begin
            case (base)
                mbfc_pkg::FC_ENC_IFACE: return 9'd6;
                mbfc_pkg::FC_READ_COILS, mbfc_pkg::FC_READ_DISCRETE,
                mbfc_pkg::FC_READ_HOLDING, mbfc_pkg::FC_READ_INPUT,
                mbfc_pkg::FC_WRITE_COIL, mbfc_pkg::FC_WRITE_REG,
                mbfc_pkg::FC_WRITE_COILS, mbfc_pkg::FC_WRITE_REGS,
                mbfc_pkg::FC_READ_FILE, mbfc_pkg::FC_WRITE_FILE,
                mbfc_pkg::FC_MASK_WRITE, mbfc_pkg::FC_RW_REGS:
                                        return 9'd5;
                default:                return '0;
            endcase
        end
        case (fc)
            mbfc_pkg::FC_READ_COILS, mbfc_pkg::FC_READ_DISCRETE,
            mbfc_pkg::FC_READ_HOLDING, mbfc_pkg::FC_READ_INPUT,
            mbfc_pkg::FC_READ_FILE, mbfc_pkg::FC_WRITE_FILE,
            mbfc_pkg::FC_RW_REGS:                          return {1'b0, h2} + 9'd5;
            mbfc_pkg::FC_WRITE_COIL, mbfc_pkg::FC_WRITE_REG,
            mbfc_pkg::FC_WRITE_COILS, mbfc_pkg::FC_WRITE_REGS: return 9'd8;
            mbfc_pkg::FC_MASK_WRITE:                       return 9'd10;
            mbfc_pkg::FC_ENC_IFACE:                        return 9'd13;
            default:                                       return '0;
        endcase
    endfunction

    // Advance the frame state by one accepted byte; queue a verdict on frame end
    function automatic void absorb_byte(logic [7:0] b, logic last);
        logic [mbfc_pkg::LEN_W-1:0] pos;
        logic [mbfc_pkg::LEN_W-1:0] cnt;
        logic [15:0]                calc;
        logic                       addr_ok;
        t_verdict                   v;
        pos = m_count;
        cnt = (pos == COUNT_TOP) ? pos : pos + 1'b1;
        case (pos)
            mbfc_pkg::POS_STATION: m_hdr[0] = b;
            mbfc_pkg::POS_FC:      m_hdr[1] = b;
            mbfc_pkg::POS_H2:      m_hdr[2] = b;
            mbfc_pkg::POS_H3:      m_hdr[3] = b;
            mbfc_pkg::POS_H4:      m_hdr[4] = b;
            default: ;
        endcase
        m_exp_len = frame_len(cfg_role, m_hdr[1], m_hdr[2], m_hdr[3], m_hdr[4]);
        // Latch the running CRC, then capture the two CRC bytes from the wire
        if (m_exp_len != 0) begin
            if (pos == m_exp_len - 9'd2) begin
                m_crc_at = m_crc;
                m_rx_crc = {b, m_rx_crc[7:0]};
            end else if (pos == m_exp_len - 9'd1) begin
                m_rx_crc[7:0] = b;
            end
        end
        m_crc   = crc_step(m_crc, b);
        m_count = cnt;
        if (!last) return;

        v.station = m_hdr[0];
        v.fc      = m_hdr[1];
        v.msg_len = '0;
        v.rx_len  = cnt;
        if (cnt < mbfc_pkg::MIN_FRAME) begin
            v.status  = mbfc_pkg::ST_SHORT;
            v.station = 8'h00;
            v.fc      = 8'h00;
        end else begin
            if (cfg_role == mbfc_pkg::ROLE_SLAVE)
                addr_ok = (v.station == cfg_addr) ||
                          (v.station == mbfc_pkg::ADDR_BROADCAST);
            else
                addr_ok = (v.station != mbfc_pkg::ADDR_BROADCAST) &&
                          (v.station <= mbfc_pkg::ADDR_MAX);
            if (!addr_ok) begin
                v.status = mbfc_pkg::ST_ADDR_REJ;
            end else if (m_exp_len == 0) begin
                v.status  = mbfc_pkg::ST_UNKNOWN_FC;
                v.msg_len = cnt;
            end else begin
                v.msg_len = m_exp_len;
                if (cnt < m_exp_len) begin
                    v.status = mbfc_pkg::ST_TRUNCATED;
                end else begin
                    calc = cfg_hi_first ? m_crc_at : {m_crc_at[7:0], m_crc_at[15:8]};
                    v.status = (calc == m_rx_crc) ? mbfc_pkg::ST_ACCEPTED
                                                  : mbfc_pkg::ST_CRC_BAD;
                end
            end
        end
        verdicts_due.push_back(v);
        m_count = '0;
        m_crc   = mbfc_pkg::CRC_INIT;
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Station address: mostly one that passes the address check
    function automatic logic [7:0] pick_station();
        int r;
        r = $urandom_range(0, 9);
        if (cfg_role == mbfc_pkg::ROLE_SLAVE) begin
            if (r < 5) return cfg_addr;
            if (r < 7) return mbfc_pkg::ADDR_BROADCAST;
        end else if (r < 8) begin
            return 8'($urandom_range(1, mbfc_pkg::ADDR_MAX));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Length field: small mostly, full range now and then
    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 6));
    endfunction

    task automatic append_crc(logic hi_first);
        logic [15:0] c;
        c = mbfc_pkg::CRC_INIT;
        foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
        if (hi_first) begin
            frame_buf.push_back(c[15:8]);
            frame_buf.push_back(c[7:0]);
        end else begin
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
        end
    endtask

    // Hand the built frame to the driver, flagging its last byte
    task automatic push_frame();
        foreach (frame_buf[i])
            tx_bytes.push_back({frame_buf[i], i == frame_buf.size() - 1});
        frames_queued++;
    endtask

    // Build one frame for the current settings into frame_buf
    task automatic make_frame(t_frame_kind kind);
        logic [7:0]                 st;
        logic [7:0]                 fc;
        logic [7:0]                 h2;
        logic [7:0]                 h3;
        logic [7:0]                 h4;
        logic [mbfc_pkg::LEN_W-1:0] len;
        int                         n;
        int                         pos;
        frame_buf.delete();
        if (kind == FR_NOISE || kind == FR_RUNT) begin
            n = (kind == FR_RUNT) ? $urandom_range(1, 3) : $urandom_range(4, 16);
            repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        st = pick_station();
        do fc = 8'($urandom_range(0, 255));
        while (frame_len(cfg_role, fc, 8'h00, 8'h00, 8'h00) == 0);
        h2  = pick_count();
        h3  = pick_count();
        h4  = pick_count();
        len = frame_len(cfg_role, fc, h2, h3, h4);
        repeat (len - 2) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[mbfc_pkg::POS_STATION] = st;
        frame_buf[mbfc_pkg::POS_FC]      = fc;
        frame_buf[mbfc_pkg::POS_H2]      = h2;
        if (len - 2 > mbfc_pkg::POS_H3) frame_buf[mbfc_pkg::POS_H3] = h3;
        if (len - 2 > mbfc_pkg::POS_H4) frame_buf[mbfc_pkg::POS_H4] = h4;
        append_crc((kind == FR_SWAP) ? !cfg_hi_first : cfg_hi_first);
        case (kind)
            FR_TAIL: repeat ($urandom_range(1, 4))
                         frame_buf.push_back(8'($urandom_range(0, 255)));
            FR_LONG: begin
                n = $urandom_range(512, 530);
                while (frame_buf.size() < n) frame_buf.push_back(8'($urandom_range(0, 255)));
            end
            FR_FLIP: begin
                pos = $urandom_range(mbfc_pkg::POS_H2, frame_buf.size() - 1);
                frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            FR_CUT: begin
                n = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > n) frame_buf.delete(frame_buf.size() - 1);
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [mbfc_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbfc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            mbfc_pkg::CFG_ROLE:           cfg_role     = val[0];
            mbfc_pkg::CFG_OWN_ADDRESS:    cfg_addr     = val;
            mbfc_pkg::CFG_CRC_HIGH_FIRST: cfg_hi_first = val[0];
            default: ;
        endcase
    endtask

    // Poll at the falling edge so every update of the rising edge has settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (tx_bytes.size() != 0 || byte_ch.valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic role, logic [7:0] addr, logic hi_first, int budget,
                             bit with_long);
        int          queued;
        int          r;
        t_frame_kind kind;
        write_reg(mbfc_pkg::CFG_ROLE, {7'd0, role});
        write_reg(mbfc_pkg::CFG_OWN_ADDRESS, addr);
        write_reg(mbfc_pkg::CFG_CRC_HIGH_FIRST, {7'd0, hi_first});
        queued = 0;
        if (with_long) begin
            make_frame(FR_LONG);
            queued += frame_buf.size();
            push_frame();
        end
        while (queued < budget) begin
            r = $urandom_range(0, 99);
            kind = (r < 50) ? FR_GOOD  : (r < 58) ? FR_TAIL  : (r < 68) ? FR_FLIP :
                   (r < 78) ? FR_CUT   : (r < 83) ? FR_SWAP  : (r < 93) ? FR_NOISE :
                   FR_RUNT;
            make_frame(kind);
            queued += frame_buf.size();
            push_frame();
        end
        wait_idle();
    endtask

    // Byte driver: hold the item until taken, idle in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            gap_left      <= 0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (gap_left != 0) begin
                byte_ch.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                byte_ch.valid <= 1'b0;
                gap_left      <= $urandom_range(0, 6);
            end else if (tx_bytes.size() != 0) begin
                drv_item = tx_bytes.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= drv_item.value;
                byte_ch.frame_end <= drv_item.last;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Verdict receiver: stall in random bursts, or for the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdict_ch.ready <= 1'b0;
            stall_left       <= 0;
        end else if (hold_out) begin
            verdict_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            verdict_ch.ready <= 1'b0;
            stall_left       <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            verdict_ch.ready <= 1'b0;
            stall_left       <= $urandom_range(0, 6);
        end else begin
            verdict_ch.ready <= 1'b1;
        end
    end

    // Predict on every accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            bytes_taken++;
            absorb_byte(byte_ch.data_byte, byte_ch.frame_end);
        end
    end

    // Compare every accepted verdict with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            verdicts_seen++;
            if (verdict_ch.status <= mbfc_pkg::ST_UNKNOWN_FC)
                verdict_tally[verdict_ch.status]++;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none due, expected nothing, got status %0d",
                         $time, verdict_ch.status);
                fail_count++;
            end else begin
                check_field("status", 9'(verdicts_due[0].status), 9'(verdict_ch.status));
                check_field("station", 9'(verdicts_due[0].station), 9'(verdict_ch.station));
                check_field("function_code", 9'(verdicts_due[0].fc),
                            9'(verdict_ch.function_code));
                check_field("message_length", verdicts_due[0].msg_len,
                            verdict_ch.message_length);
                check_field("received_length", verdicts_due[0].rx_len,
                            verdict_ch.received_length);
                verdicts_due.delete(0);
            end
        end
    end

    // Long receiver hold-off early in the directed frames, while several frame ends
    // are still queued, so the result register fills and the input stalls
    initial begin
        wait (bytes_taken >= HOLD_AFTER);
        @(posedge i_clk);
        hold_out <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    // Run limit
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = 8'h00;
        byte_ch.frame_end    = 1'b0;
        verdict_ch.ready     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a long first frame fills every header slot, then runts and a broadcast
        write_reg(mbfc_pkg::CFG_ROLE, {7'd0, mbfc_pkg::ROLE_SLAVE});
        write_reg(mbfc_pkg::CFG_OWN_ADDRESS, mbfc_pkg::OWN_ADDRESS_RST);
        write_reg(mbfc_pkg::CFG_CRC_HIGH_FIRST, 8'd0);
        frame_buf = '{mbfc_pkg::OWN_ADDRESS_RST, mbfc_pkg::FC_READ_HOLDING,
                      8'h00, 8'hFF, 8'h00, 8'h0A};
        append_crc(1'b0);
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h55);
        frame_buf.push_back(8'hAA);
        push_frame();
        frame_buf = '{8'hFF};
        push_frame();
        frame_buf = '{8'h00, 8'hFF, 8'h00};
        push_frame();
        frame_buf = '{mbfc_pkg::ADDR_BROADCAST, mbfc_pkg::FC_WRITE_REG,
                      8'h00, 8'h01, 8'hFF, 8'h00};
        append_crc(1'b0);
        push_frame();
        wait_idle();

        // Random frames under several settings, extremes included
        run_phase(mbfc_pkg::ROLE_SLAVE, mbfc_pkg::OWN_ADDRESS_RST, 1'b0, 50, 1'b0);
        run_phase(mbfc_pkg::ROLE_SLAVE, mbfc_pkg::ADDR_MAX, 1'b1, 50, 1'b0);
        run_phase(mbfc_pkg::ROLE_MASTER, 8'd17, 1'b0, 50, 1'b0);
        run_phase(mbfc_pkg::ROLE_MASTER, 8'd200, 1'b1, 540, 1'b1);
        run_phase(mbfc_pkg::ROLE_SLAVE, 8'hFF, 1'b0, 50, 1'b0);
        run_phase(mbfc_pkg::ROLE_SLAVE, 8'($urandom_range(1, mbfc_pkg::ADDR_MAX)),
                  1'($urandom_range(0, 1)), 50, 1'b0);
        quiet = 1'b1;
        run_phase(mbfc_pkg::ROLE_MASTER, mbfc_pkg::ADDR_BROADCAST, 1'b1, 70, 1'b0);

        $display("tb: run took %0d bytes in %0d frames over 7 settings, %0d verdicts checked",
                 bytes_taken, frames_queued, verdicts_seen);
        $display("tb: short %0d, address %0d, accepted %0d, crc %0d, truncated %0d, unknown %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2],
                 verdict_tally[3], verdict_tally[4], verdict_tally[5]);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
